@@ rtl/md5_pkg.sv @@
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BufDepth = 16;
  localparam int unsigned BufAddrW = 4;
  localparam int unsigned RoundW = 6;
  localparam int unsigned CountW = 64;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LastPos = 6'h3F;
  localparam logic [5:0] LenPos  = 6'd56;

  localparam logic [3:0][WordW-1:0] ChainInit = {
    32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  typedef struct packed {
    logic start;
    logic reload;
  } core_ctrl_t;

  typedef struct packed {
    logic done;
  } core_stat_t;

  function automatic logic [WordW-1:0] round_const(input logic [RoundW-1:0] r);
    logic [WordW-1:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [RoundW-1:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [BufAddrW-1:0] msg_index(input logic [RoundW-1:0] r);
    logic [BufAddrW-1:0] lo;
    logic [BufAddrW-1:0] g;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    g = lo;
      2'd1:    g = BufAddrW'((lo << 2) + lo + 4'd1);
      2'd2:    g = BufAddrW'((lo << 1) + lo + 4'd5);
      default: g = BufAddrW'((lo << 3) - lo);
    endcase
    return g;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input logic [4:0] s);
    logic [2*WordW-1:0] t;
    t = {x, x} << s;
    return t[2*WordW-1:WordW];
  endfunction

endpackage

`default_nettype wire

@@ rtl/md5_digest_top.sv @@
// ----------------------------------------------------------------------------
// md5_digest_top
// Streaming MD5 digest: bytes in, four little-endian digest words out.
// ----------------------------------------------------------------------------
//  channel   dir   tdata                     tuser          tlast
//  s_axis    in    [7:0] data_byte           carries_byte   end_of_message
//  m_axis    out   [31:0] digest_word        word_index     last_word
//
//  A message byte is taken while the block is idle; the 64th byte of a
//  block starts a compression (buffer read prime, 64 rounds in the shared
//  round unit, fold), during which no item is taken. An end item adds
//  9 to 72 padding bytes, written to the buffer one by one, plus one or
//  two compressions, then four output items. Reset is asynchronous, active
//  low; an output item holds until m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_digest_top
  import md5_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] carries_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic      [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic             m_axis_tlast
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StPad  = 4'b0010,
    StComp = 4'b0100,
    StOut  = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;
  logic [5:0]        pos_q, pos_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              pad_q, pad_d;
  logic              first_q, first_d;
  logic              len_q, len_d;
  logic [1:0]        idx_q, idx_d;
  logic [23:0]       asm_q;

  logic              in_acc, out_acc, wr_en, mem_we;
  logic [7:0]        wr_byte, pad_byte;
  logic [CountW-1:0] cnt_sh;
  logic [BufAddrW-1:0] raddr;
  logic [WordW-1:0]  rdata;
  logic [3:0][WordW-1:0] chain;
  core_ctrl_t        ctrl;
  core_stat_t        stat;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == StOut);
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = chain[idx_q];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == 2'd3);

  assign cnt_sh = cnt_q >> {pos_q[2:0], 3'b000};

  always_comb begin
    if (first_q) begin
      pad_byte = PadByte;
    end else if (len_q) begin
      pad_byte = cnt_sh[7:0];
    end else begin
      pad_byte = '0;
    end
  end

  assign wr_en   = (state_q == StPad) || (in_acc && s_axis_tuser);
  assign wr_byte = (state_q == StPad) ? pad_byte : s_axis_tdata;
  assign mem_we  = wr_en && (pos_q[1:0] == 2'd3);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    pad_d       = pad_q;
    first_d     = first_q;
    len_d       = len_q;
    idx_d       = idx_q;
    ctrl.start  = 1'b0;
    ctrl.reload = 1'b0;
    if (wr_en) begin
      pos_d = pos_q + 6'd1;
    end
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            cnt_d = cnt_q + CountW'(8);
          end
          if (s_axis_tlast) begin
            pad_d   = 1'b1;
            first_d = 1'b1;
          end
          if (s_axis_tuser && (pos_q == LastPos)) begin
            ctrl.start = 1'b1;
            state_d    = StComp;
          end else if (s_axis_tlast) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        first_d = 1'b0;
        if (!len_q && (pos_d == LenPos)) begin
          len_d = 1'b1;
        end
        if (pos_q == LastPos) begin
          ctrl.start = 1'b1;
          state_d    = StComp;
        end
      end
      StComp: begin
        if (stat.done) begin
          if (len_q) begin
            state_d = StOut;
          end else if (pad_q) begin
            state_d = StPad;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StOut: begin
        if (out_acc) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            ctrl.reload = 1'b1;
            cnt_d   = '0;
            pos_d   = '0;
            pad_d   = 1'b0;
            len_d   = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      cnt_q   <= '0;
      pad_q   <= 1'b0;
      first_q <= 1'b0;
      len_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      pad_q   <= pad_d;
      first_q <= first_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !mem_we) begin
      case (pos_q[1:0])
        2'd0:    asm_q[7:0]   <= wr_byte;
        2'd1:    asm_q[15:8]  <= wr_byte;
        default: asm_q[23:16] <= wr_byte;
      endcase
    end
  end

  md5_buf u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pos_q[5:2]),
    .wdata_i ({wr_byte, asm_q}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  md5_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .chain_o (chain)
  );

endmodule

`default_nettype wire

@@ rtl/md5_buf.sv @@
// ----------------------------------------------------------------------------
// md5_buf
// Block buffer: 16 x 32-bit memory, one write port, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_buf
  import md5_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [BufAddrW-1:0] waddr_i,
  input  wire logic [WordW-1:0]    wdata_i,
  input  wire logic [BufAddrW-1:0] raddr_i,
  output logic      [WordW-1:0]    rdata_o
);

  logic [WordW-1:0] mem [BufDepth];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/md5_core.sv @@
// ----------------------------------------------------------------------------
// md5_core
// Compression unit: one MD5 round per cycle over the block buffer, then
// folds the working words into the chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_core
  import md5_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire core_ctrl_t             ctrl_i,
  output core_stat_t                  stat_o,
  output logic      [BufAddrW-1:0]    raddr_o,
  input  wire logic [WordW-1:0]       rdata_i,
  output logic      [3:0][WordW-1:0]  chain_o
);

  typedef enum logic [3:0] {
    CoreIdle  = 4'b0001,
    CorePrime = 4'b0010,
    CoreRound = 4'b0100,
    CoreFold  = 4'b1000
  } core_state_e;

  core_state_e state_q, state_d;
  logic [RoundW-1:0] rnd_q, rnd_d;
  logic [3:0][WordW-1:0] chain_q;
  logic [WordW-1:0] a_q, b_q, c_q, d_q;
  logic [WordW-1:0] f_fn, f_sum, b_new;
  logic [RoundW-1:0] rnd_next;

  assign rnd_next = rnd_q + RoundW'(1);

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f_fn = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_fn = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f_fn = b_q ^ c_q ^ d_q;
      default: f_fn = c_q ^ (b_q | ~d_q);
    endcase
    f_sum = a_q + f_fn + round_const(rnd_q) + rdata_i;
    b_new = b_q + rotl(f_sum, rot_amount(rnd_q));
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    raddr_o = msg_index(rnd_next);
    unique case (state_q)
      CoreIdle: begin
        raddr_o = msg_index('0);
        if (ctrl_i.start) begin
          state_d = CorePrime;
        end
      end
      CorePrime: begin
        raddr_o = msg_index('0);
        rnd_d   = '0;
        state_d = CoreRound;
      end
      CoreRound: begin
        rnd_d = rnd_next;
        if (rnd_q == '1) begin
          state_d = CoreFold;
        end
      end
      CoreFold: begin
        state_d = CoreIdle;
      end
      default: state_d = CoreIdle;
    endcase
  end

  assign stat_o.done = (state_q == CoreFold);
  assign chain_o     = chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CoreIdle;
      rnd_q   <= '0;
      chain_q <= ChainInit;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      if (state_q == CoreFold) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end else if (ctrl_i.reload) begin
        chain_q <= ChainInit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == CorePrime) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (state_q == CoreRound) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_new;
    end
  end

endmodule

`default_nettype wire
